/* design/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the ADTS frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int FRAME_COUNT_BITS = 16;
  localparam int NUM_W = 16;
  localparam int LEN_W = 13;
  localparam int HDR_BYTES = 7;
  localparam int HDR_STORE = HDR_BYTES - 1;
  localparam int POS_W = $clog2(HDR_BYTES);
  localparam logic [POS_W-1:0] HDR_LAST_IDX = POS_W'(HDR_BYTES - 1);
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(HDR_BYTES);

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef logic [FRAME_COUNT_BITS-1:0] frame_cnt_t;

  typedef struct packed {
    logic                  is_hdr;
    logic [HDR_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]      length;
    logic [1:0]            profile;
    logic [3:0]            freq_index;
    logic [NUM_W-1:0]      number;
    logic                  last;
  } entry_t;

  function automatic logic [NUM_W-1:0] to_num(input frame_cnt_t c);
    return NUM_W'(c);
  endfunction

endpackage

/* design/adts_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// adts_frame_deframer_top
// ADTS deframer: sync hunt, header field extraction and tagged byte output.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while its four-entry queue has
// room. A completed header leaves as seven output beats and each payload
// byte as one beat. The first beat of a frame is offered when its header
// entry, queued with the seventh header byte, reaches the queue head. While
// a header plays out, the queue is full after three more bytes have been
// pushed, so with bytes and output ready on every cycle the input is held once
// a frame of ten bytes or more has queued its third payload byte and never
// otherwise; a stalled output adds its own stall cycles once the queue is full.
// Bytes outside a frame and headers with a length below seven are dropped.
module adts_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic [afd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [1:0]                    out_profile,
  output logic [3:0]                    out_freq_index,
  output logic [afd_pkg::NUM_W-1:0]     out_frame_number,
  output logic                          out_first_of_frame,
  output logic                          out_last_of_frame
);

  afd_pkg::entry_t push_entry, head;
  logic            push, pop, q_full, q_empty;

  afd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  afd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  afd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_frame_length   (out_frame_length),
    .out_profile        (out_profile),
    .out_freq_index     (out_freq_index),
    .out_frame_number   (out_frame_number),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule

/* design/afd_front.sv */
// ----------------------------------------------------------------------------
// afd_front
// Sync hunt and header capture; pushes one queue entry per completed header
// with a length of seven or more and per payload byte.
// ----------------------------------------------------------------------------
module afd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                push,
  output afd_pkg::entry_t     push_entry
);

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_HEADER,
    MODE_PAYLOAD
  } mode_t;

  mode_t                                  mode_r, mode_nxt;
  logic [7:0]                             hdr_r [afd_pkg::HDR_STORE];
  logic [7:0]                             hdr_nxt [afd_pkg::HDR_STORE];
  logic [afd_pkg::POS_W-1:0]              pos_r, pos_nxt;
  logic [afd_pkg::LEN_W-1:0]              rem_r, rem_nxt;
  logic [afd_pkg::LEN_W-1:0]              len_r, len_nxt;
  logic [1:0]                             prof_r, prof_nxt;
  logic [3:0]                             freq_r, freq_nxt;
  afd_pkg::frame_cnt_t                    cnt_r, cnt_nxt;
  logic [afd_pkg::LEN_W-1:0]              hdr_len;
  logic                                   acc;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign hdr_len = {hdr_r[3][1:0], hdr_r[4], hdr_r[5][7:5]};

  always_comb begin
    mode_nxt = mode_r;
    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    len_nxt = len_r;
    prof_nxt = prof_r;
    freq_nxt = freq_r;
    cnt_nxt = cnt_r;
    push = 1'b0;
    for (int i = 0; i < afd_pkg::HDR_STORE; i++) begin
      push_entry.bytes[i] = hdr_r[i];
    end
    push_entry.bytes[afd_pkg::HDR_BYTES-1] = in_byte;
    push_entry.is_hdr = 1'b0;
    push_entry.length = len_r;
    push_entry.profile = prof_r;
    push_entry.freq_index = freq_r;
    push_entry.number = afd_pkg::to_num(cnt_r - afd_pkg::frame_cnt_t'(1));
    push_entry.last = 1'b0;
    if (acc) begin
      unique case (mode_r)
        MODE_PAYLOAD: begin
          rem_nxt = rem_r - afd_pkg::LEN_W'(1);
          push = 1'b1;
          push_entry.bytes[0] = in_byte;
          push_entry.last = (rem_nxt == '0);
          if (rem_nxt == '0) begin
            mode_nxt = MODE_HUNT;
          end
        end
        MODE_HEADER: begin
          if (pos_r == afd_pkg::POS_W'(1)) begin
            if (in_byte[7:4] == afd_pkg::SYNC_NIBBLE) begin
              hdr_nxt[1] = in_byte;
              pos_nxt = afd_pkg::POS_W'(2);
            end else if (in_byte == afd_pkg::SYNC_BYTE) begin
              hdr_nxt[0] = in_byte;
              pos_nxt = afd_pkg::POS_W'(1);
            end else begin
              mode_nxt = MODE_HUNT;
              pos_nxt = '0;
            end
          end else if (pos_r < afd_pkg::HDR_LAST_IDX) begin
            hdr_nxt[pos_r] = in_byte;
            pos_nxt = pos_r + afd_pkg::POS_W'(1);
          end else begin
            pos_nxt = '0;
            if (hdr_len < afd_pkg::MIN_LEN) begin
              mode_nxt = MODE_HUNT;
            end else begin
              push = 1'b1;
              push_entry.is_hdr = 1'b1;
              push_entry.length = hdr_len;
              push_entry.profile = hdr_r[2][7:6];
              push_entry.freq_index = hdr_r[2][5:2];
              push_entry.number = afd_pkg::to_num(cnt_r);
              push_entry.last = (hdr_len == afd_pkg::MIN_LEN);
              len_nxt = hdr_len;
              prof_nxt = hdr_r[2][7:6];
              freq_nxt = hdr_r[2][5:2];
              cnt_nxt = cnt_r + afd_pkg::frame_cnt_t'(1);
              rem_nxt = hdr_len - afd_pkg::MIN_LEN;
              mode_nxt = (hdr_len == afd_pkg::MIN_LEN) ? MODE_HUNT : MODE_PAYLOAD;
            end
          end
        end
        default: begin
          mode_nxt = MODE_HUNT;
          if (in_byte == afd_pkg::SYNC_BYTE) begin
            hdr_nxt[0] = in_byte;
            pos_nxt = afd_pkg::POS_W'(1);
            mode_nxt = MODE_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    prof_r <= prof_nxt;
    freq_r <= freq_nxt;
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      pos_r <= '0;
      rem_r <= '0;
      len_r <= '0;
      cnt_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
      rem_r <= rem_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/afd_fifo.sv */
// ----------------------------------------------------------------------------
// afd_fifo
// Short register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module afd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  afd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output afd_pkg::entry_t head,
  output logic            empty
);

  afd_pkg::entry_t                 mem_r [afd_pkg::Q_DEPTH];
  logic [afd_pkg::Q_AW-1:0]        wr_r, rd_r;
  logic [afd_pkg::Q_CW-1:0]        cnt_r;
  logic                            do_push, do_pop;

  assign full = (cnt_r == afd_pkg::Q_CW'(afd_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + afd_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + afd_pkg::Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + afd_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - afd_pkg::Q_CW'(1);
      end
    end
  end

endmodule

/* design/afd_back.sv */
// ----------------------------------------------------------------------------
// afd_back
// Emitter: plays out a header entry as seven beats, a payload entry as one.
// ----------------------------------------------------------------------------
module afd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afd_pkg::entry_t               head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic [afd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [1:0]                    out_profile,
  output logic [3:0]                    out_freq_index,
  output logic [afd_pkg::NUM_W-1:0]     out_frame_number,
  output logic                          out_first_of_frame,
  output logic                          out_last_of_frame
);

  logic [afd_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic                      at_end;
  logic                      beat;

  assign out_valid = !empty;
  assign beat = out_valid && out_ready;
  assign at_end = !head.is_hdr || (idx_r == afd_pkg::HDR_LAST_IDX);
  assign pop = beat && at_end;

  assign out_byte = head.bytes[idx_r];
  assign out_frame_length = head.length;
  assign out_profile = head.profile;
  assign out_freq_index = head.freq_index;
  assign out_frame_number = head.number;
  assign out_first_of_frame = head.is_hdr && (idx_r == '0);
  assign out_last_of_frame = head.last && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (beat) begin
      idx_nxt = at_end ? '0 : idx_r + afd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

/* tb/adts_frame_deframer_top_test.sv */
// ----------------------------------------------------------------------------
// adts_frame_deframer_top_test
// Self-checking bench for the ADTS deframer: it streams noise, broken headers
// and well-formed frames with random content, and checks every output beat
// against a cycle-free model of the sync hunt, header parse and payload count.
// ----------------------------------------------------------------------------
module adts_frame_deframer_top_test;

  typedef enum logic [1:0] {PM_HUNT, PM_HEADER, PM_PAYLOAD} parse_mode_t;

  typedef struct packed {
    logic [7:0]                data;
    logic [afd_pkg::LEN_W-1:0] len;
    logic [1:0]                profile;
    logic [3:0]                freq;
    logic [afd_pkg::NUM_W-1:0] num;
    logic                      is_first;
    logic                      is_last;
  } beat_t;

  class frame_scoreboard;
    parse_mode_t               mode;
    logic [7:0]                hdr [afd_pkg::HDR_STORE];
    logic [afd_pkg::POS_W-1:0] hdr_pos;
    logic [afd_pkg::LEN_W-1:0] remaining;
    logic [afd_pkg::LEN_W-1:0] cur_len;
    afd_pkg::frame_cnt_t       frame_cnt;
    beat_t                     pending_beats [$];
    int                        mismatches;
    int                        beats_checked;
    int                        frames_found;
    int                        false_syncs;
    int                        bytes_taken;

    function new();
      mode = PM_HUNT;
      hdr_pos = '0;
      remaining = '0;
      cur_len = '0;
      frame_cnt = '0;
      mismatches = 0;
      beats_checked = 0;
      frames_found = 0;
      false_syncs = 0;
      bytes_taken = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    function void queue_beat(logic [7:0] data, logic is_first, logic is_last,
                             logic [afd_pkg::NUM_W-1:0] num);
      beat_t b;
      b.data = data;
      b.len = cur_len;
      b.profile = hdr[2][7:6];
      b.freq = hdr[2][5:2];
      b.num = num;
      b.is_first = is_first;
      b.is_last = is_last;
      pending_beats.push_back(b);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [afd_pkg::LEN_W-1:0] hlen;
      logic [afd_pkg::NUM_W-1:0] num;
      bytes_taken++;
      case (mode)
        PM_PAYLOAD: begin
          remaining = remaining - 1'b1;
          queue_beat(b, 1'b0, remaining == 0, afd_pkg::NUM_W'(frame_cnt - 1'b1));
          if (remaining == 0) mode = PM_HUNT;
        end
        PM_HEADER: begin
          if (hdr_pos == 1) begin
            if (b[7:4] == afd_pkg::SYNC_NIBBLE) begin
              hdr[1] = b;
              hdr_pos = 2;
            end else if (b == afd_pkg::SYNC_BYTE) begin
              hdr[0] = b;
              hdr_pos = 1;
            end else begin
              mode = PM_HUNT;
              hdr_pos = '0;
            end
          end else if (hdr_pos < afd_pkg::HDR_LAST_IDX) begin
            hdr[hdr_pos] = b;
            hdr_pos++;
          end else begin
            hlen = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
            hdr_pos = '0;
            if (hlen < afd_pkg::MIN_LEN) begin
              mode = PM_HUNT;
              false_syncs++;
            end else begin
              cur_len = hlen;
              num = afd_pkg::NUM_W'(frame_cnt);
              frame_cnt++;
              frames_found++;
              for (int i = 0; i < afd_pkg::HDR_STORE; i++)
                queue_beat(hdr[i], i == 0, 1'b0, num);
              queue_beat(b, 1'b0, hlen == afd_pkg::MIN_LEN, num);
              if (hlen == afd_pkg::MIN_LEN) begin
                mode = PM_HUNT;
                remaining = '0;
              end else begin
                mode = PM_PAYLOAD;
                remaining = hlen - afd_pkg::MIN_LEN;
              end
            end
          end
        end
        default: begin
          mode = PM_HUNT;
          if (b == afd_pkg::SYNC_BYTE) begin
            hdr[0] = b;
            hdr_pos = 1;
            mode = PM_HEADER;
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat 0x%02h arrived with nothing pending", got.data));
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (got.data !== want.data)
          report($sformatf("byte got %02h want %02h", got.data, want.data));
        if (got.len !== want.len)
          report($sformatf("frame length got %0d want %0d", got.len, want.len));
        if (got.profile !== want.profile)
          report($sformatf("profile got %0d want %0d", got.profile, want.profile));
        if (got.freq !== want.freq)
          report($sformatf("freq index got %0d want %0d", got.freq, want.freq));
        if (got.num !== want.num)
          report($sformatf("frame number got %0d want %0d", got.num, want.num));
        if (got.is_first !== want.is_first)
          report($sformatf("first flag got %b want %b", got.is_first, want.is_first));
        if (got.is_last !== want.is_last)
          report($sformatf("last flag got %b want %b", got.is_last, want.is_last));
      end
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                in_byte;
  logic                      out_valid;
  logic                      out_ready;
  logic [7:0]                out_byte;
  logic [afd_pkg::LEN_W-1:0] out_frame_length;
  logic [1:0]                out_profile;
  logic [3:0]                out_freq_index;
  logic [afd_pkg::NUM_W-1:0] out_frame_number;
  logic                      out_first_of_frame;
  logic                      out_last_of_frame;

  frame_scoreboard sb;
  logic            tx_calm;
  int              sent_bytes;

  adts_frame_deframer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_frame_length   (out_frame_length),
    .out_profile        (out_profile),
    .out_freq_index     (out_freq_index),
    .out_frame_number   (out_frame_number),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    beat_t got;
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready) sb.note_byte(in_byte);
      if (out_valid && out_ready) begin
        got = {out_byte, out_frame_length, out_profile, out_freq_index,
               out_frame_number, out_first_of_frame, out_last_of_frame};
        sb.check_beat(got);
      end
    end
  end

  initial begin : receiver
    int stall;
    int calm;
    calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
      stall = (calm != 0) ? 0 : $urandom_range(0, 3);
      if (calm != 0) calm--;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_header(input logic [afd_pkg::LEN_W-1:0] hlen, input logic [7:0] b2);
    send_byte(afd_pkg::SYNC_BYTE);
    send_byte({afd_pkg::SYNC_NIBBLE, 4'($urandom)});
    send_byte(b2);
    send_byte({6'($urandom), hlen[12:11]});
    send_byte(hlen[10:3]);
    send_byte({hlen[2:0], 5'($urandom)});
    send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [afd_pkg::LEN_W-1:0] hlen, input logic [7:0] b2);
    send_header(hlen, b2);
    for (int i = afd_pkg::MIN_LEN; i < hlen; i++)
      send_byte(($urandom_range(0, 15) == 0) ? afd_pkg::SYNC_BYTE : 8'($urandom));
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int pick;
    logic [afd_pkg::LEN_W-1:0] hlen;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_ready = 1'b0;
    tx_calm = 1'b0;
    sent_bytes = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(afd_pkg::SYNC_BYTE);
    send_byte(8'h0F);
    // This sync byte starts a new candidate header, in which the next header's sync byte is taken as the second byte.
    send_byte(afd_pkg::SYNC_BYTE);
    send_header(afd_pkg::LEN_W'(afd_pkg::HDR_BYTES), 8'h00);
    send_header(afd_pkg::LEN_W'(afd_pkg::HDR_BYTES - 1), 8'hFF);
    send_header(afd_pkg::LEN_W'(afd_pkg::HDR_BYTES + 2), 8'hFF);
    send_byte(afd_pkg::SYNC_BYTE);
    send_byte(8'hF1);
    drain_outputs();

    while (sent_bytes < 250) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        hlen = ($urandom_range(0, 15) == 0) ? afd_pkg::LEN_W'($urandom_range(25, 60))
                                            : afd_pkg::LEN_W'($urandom_range(7, 20));
        send_frame(hlen, 8'($urandom));
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
      end else if (pick == 8) begin
        send_header(afd_pkg::LEN_W'($urandom_range(0, afd_pkg::HDR_BYTES - 1)),
                    8'($urandom));
      end else begin
        send_byte(afd_pkg::SYNC_BYTE);
        send_byte(8'($urandom_range(0, 8'hEF)));
      end
      if ($urandom_range(0, 19) == 0) drain_outputs();
    end

    // The stream ends inside the largest possible frame, so only its header comes out.
    tx_calm = 1'b0;
    send_header({afd_pkg::LEN_W{1'b1}}, 8'($urandom));
    drain_outputs();
    repeat (20) @(posedge clk);

    $display("run covered %0d input bytes, %0d frames, %0d false syncs",
             sb.bytes_taken, sb.frames_found, sb.false_syncs);
    $display("%0d output beats checked, %0d mismatches", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("timeout waiting for the deframer");
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
design/afd_pkg.sv
design/afd_front.sv
design/afd_fifo.sv
design/afd_back.sv
design/adts_frame_deframer_top.sv
tb/adts_frame_deframer_top_test.sv
